@@ design/lcd4_pkg.sv @@
// Shared types and constants for the four-bit character display sequencer.
// Used by the front end, the request queue, the phase generator and the top level.
// No dependencies.
package lcd4_pkg;

    // Request kinds carried in the input tuser field.
    typedef enum logic [1:0] {
        REQ_INIT   = 2'd0,
        REQ_CMD    = 2'd1,
        REQ_DATA   = 2'd2,
        REQ_CURSOR = 2'd3
    } t_req;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SHORT_UNIT   = 3'd0;
    localparam logic [2:0] CFG_MILLISECOND  = 3'd1;
    localparam logic [2:0] CFG_FUNCTION_SET = 3'd2;
    localparam logic [2:0] CFG_DISPLAY_CTRL = 3'd3;
    localparam logic [2:0] CFG_ENTRY_MODE   = 3'd4;

    // Display commands and addresses.
    localparam logic [7:0] CMD_CLEAR  = 8'h01;
    localparam logic [7:0] CMD_HOME   = 8'h02;
    localparam logic [7:0] LINE0_ADDR = 8'h80;
    localparam logic [7:0] LINE1_ADDR = 8'hC0;

    // Nibbles of the power-on wake-up run.
    localparam logic [3:0] NIB_WAKE  = 4'h3;
    localparam logic [3:0] NIB_4BIT  = 4'h2;
    localparam logic [3:0] NIB_IDLE  = 4'h0;

    // Phase counts.
    localparam int PREFIX_PHASES = 9;
    localparam int INIT_PHASES   = 25;
    localparam int BYTE_PHASES   = 4;
    localparam int STEP_W        = 5;
    localparam int WAIT_W        = 24;

    // Delay multiples, in short units and in milliseconds.
    localparam logic [4:0] U_PULSE    = 5'd5;
    localparam logic [4:0] U_POST     = 5'd10;
    localparam logic [4:0] U_WAKE     = 5'd20;
    localparam logic [4:0] MS_NONE    = 5'd0;
    localparam logic [4:0] MS_LONG    = 5'd2;
    localparam logic [4:0] MS_WAKE1   = 5'd5;
    localparam logic [4:0] MS_POWERUP = 5'd20;

    // One queued job: either the whole init run or one byte.
    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] byte_val;
    } t_job;

    // Live configuration.
    typedef struct packed {
        logic [7:0]  short_unit_ticks;
        logic [15:0] millisecond_ticks;
        logic [7:0]  function_set_byte;
        logic [7:0]  display_control_byte;
        logic [7:0]  entry_mode_byte;
    } t_cfg;

    // One pin phase as it leaves the block.
    typedef struct packed {
        logic              last;
        logic [WAIT_W-1:0] wait_ticks;
        logic [3:0]        nibble;
        logic              en;
        logic              rs;
    } t_phase;

endpackage

@@ design/lcd4_front.sv @@
// Front end: takes requests and turns each into a queued job.
// Depends on lcd4_pkg.
module lcd4_front (
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [15:0]   i_s_axis_tdata,  // [7:0] byte_value, [8] row, [14:9] column, [15] zero
    input  logic [1:0]    i_s_axis_tuser,  // [1:0] req_type
    input  logic          i_q_full,
    output logic          o_push,
    output lcd4_pkg::t_job o_job
);
    import lcd4_pkg::*;

    logic [7:0] byte_value;
    logic       row;
    logic [5:0] column;
    logic [7:0] base_addr;

    assign byte_value = i_s_axis_tdata[7:0];
    assign row        = i_s_axis_tdata[8];
    assign column     = i_s_axis_tdata[14:9];
    assign base_addr  = row ? LINE1_ADDR : LINE0_ADDR;

    // A request is taken whenever the queue has room.
    assign o_s_axis_tready = !i_q_full;
    assign o_push          = i_s_axis_tvalid && !i_q_full;

    // Classify the request into a job.
    always_comb begin
        o_job = '0;
        case (t_req'(i_s_axis_tuser)) 
            REQ_INIT: begin
                o_job.is_init = 1'b1;
            end
            REQ_CMD: begin
                o_job.byte_val = byte_value;
            end
            REQ_DATA: begin
                o_job.rs       = 1'b1;
                o_job.byte_val = byte_value;
            end
            REQ_CURSOR: begin
                o_job.byte_val = base_addr + {2'b00, column};
            end
            default: begin
                o_job = '0;
            end
        endcase
    end

endmodule

@@ design/lcd4_queue.sv @@
// Short job queue between the front end and the phase generator.
// Depends on lcd4_pkg.
module lcd4_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lcd4_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output lcd4_pkg::t_job o_job
);
    import lcd4_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and count update with wrap at the depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // The count never exceeds the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    // A push into a non-full queue without a pop raises the count by one.
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow push");

    // Read and write pointers meet only when the queue is empty or full.
    a_ptr_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr == r_rd_ptr) |-> (!o_valid || o_full))
        else $error("queue pointers inconsistent with count");

endmodule

@@ design/lcd4_back.sv @@
// Phase generator: walks each job through its pin phases into an output register.
// Depends on lcd4_pkg.
module lcd4_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lcd4_pkg::t_cfg i_cfg,
    input  logic           i_q_valid,
    input  lcd4_pkg::t_job i_q_job,
    output logic           o_q_pop,
    output logic           o_m_axis_tvalid,
    input  logic           i_m_axis_tready,
    output lcd4_pkg::t_phase o_phase
);
    import lcd4_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    t_job              r_job, n_job;
    logic              r_out_valid, n_out_valid;
    t_phase            r_out, n_out;

    t_phase            phase;
    logic              slot_free, advance;
    logic [STEP_W-1:0] rel;
    logic [1:0]        k;
    logic [1:0]        bidx;
    logic              in_prefix;
    logic [7:0]        cur_byte;
    logic              long_cmd;
    logic [4:0]        units_n, ms_n;
    logic [12:0]       unit_prod;
    logic [20:0]       ms_prod;

    assign slot_free = !r_out_valid || i_m_axis_tready;
    assign advance   = (r_state == S_RUN) && slot_free;

    // Locate the current byte and nibble within the job.
    assign in_prefix = r_job.is_init && (r_step < STEP_W'(PREFIX_PHASES));
    assign rel       = r_job.is_init ? (r_step - STEP_W'(PREFIX_PHASES)) : r_step;
    assign k         = rel[1:0];
    assign bidx      = rel[3:2];

    always_comb begin
        if (r_job.is_init) begin
            case (bidx)
                2'd0:    cur_byte = i_cfg.function_set_byte;
                2'd1:    cur_byte = i_cfg.display_control_byte;
                2'd2:    cur_byte = i_cfg.entry_mode_byte;
                default: cur_byte = CMD_CLEAR;
            endcase
        end else begin
            cur_byte = r_job.byte_val;
        end
    end

    assign long_cmd = !r_job.rs && ((cur_byte == CMD_CLEAR) || (cur_byte == CMD_HOME));

    // Decode the pin levels and the delay multiples of the current phase.
    always_comb begin
        phase.rs   = r_job.rs;
        phase.last = 1'b0;
        if (in_prefix) begin
            case (r_step[3:0])
                4'd0: begin
                    phase.en = 1'b0; phase.nibble = NIB_IDLE;
                    units_n = 5'd0; ms_n = MS_POWERUP;
                end
                4'd2: begin
                    phase.en = 1'b0; phase.nibble = NIB_WAKE;
                    units_n = U_PULSE; ms_n = MS_WAKE1;
                end
                4'd4, 4'd6: begin
                    phase.en = 1'b0; phase.nibble = NIB_WAKE;
                    units_n = U_WAKE; ms_n = MS_NONE;
                end
                4'd7: begin
                    phase.en = 1'b1; phase.nibble = NIB_4BIT;
                    units_n = U_PULSE; ms_n = MS_NONE;
                end
                4'd8: begin
                    phase.en = 1'b0; phase.nibble = NIB_4BIT;
                    units_n = U_WAKE; ms_n = MS_NONE;
                end
                default: begin
                    // Rising halves of the wake-up pulses.
                    phase.en = 1'b1; phase.nibble = NIB_WAKE;
                    units_n = U_PULSE; ms_n = MS_NONE;
                end
            endcase
        end else begin
            phase.en     = !k[0];
            phase.nibble = k[1] ? cur_byte[3:0] : cur_byte[7:4];
            units_n      = U_PULSE;
            ms_n         = MS_NONE;
            if (k == 2'd3) begin
                // Settling delay after the byte, long for clear and home.
                units_n    = long_cmd ? U_PULSE : U_POST;
                ms_n       = long_cmd ? MS_LONG : MS_NONE;
                phase.last = !r_job.is_init || (bidx == 2'd3);
                // The init run ends with a further long delay.
                if (r_job.is_init && (bidx == 2'd3)) begin
                    ms_n = ms_n + MS_LONG;
                end
            end
        end
        // Hold time from the two delay multiples.
        unit_prod        = 13'(units_n) * 13'(i_cfg.short_unit_ticks);
        ms_prod          = 21'(ms_n) * 21'(i_cfg.millisecond_ticks);
        phase.wait_ticks = WAIT_W'(unit_prod) + WAIT_W'(ms_prod);
    end

    // Sequencer: load a job, emit one phase per free output slot.
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_job       = r_job;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_q_pop     = 1'b0;
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_job   = i_q_job;
                    n_step  = '0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (advance) begin
                    n_out       = phase;
                    n_out_valid = 1'b1;
                    n_step      = r_step + 1'b1;
                    if (phase.last) begin
                        if (i_q_valid) begin
                            o_q_pop = 1'b1;
                            n_job   = i_q_job;
                            n_step  = '0;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_out <= n_out;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_phase         = r_out;

    // A byte job never runs past its four phases.
    a_byte_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && !r_job.is_init) |-> (r_step < STEP_W'(BYTE_PHASES)))
        else $error("byte job ran past its last phase");

    // An init job never runs past its twenty-five phases.
    a_init_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_step < STEP_W'(INIT_PHASES)))
        else $error("init job ran past its last phase");

    // A final phase shows up on the output with its end mark.
    a_last_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && phase.last) |=> (r_out_valid && r_out.last))
        else $error("final phase lost its end mark");

    // Taking a job starts it at its first phase.
    a_pop_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == S_RUN && r_step == '0))
        else $error("job not started at first phase");

endmodule

@@ design/char_lcd_4bit_interface_sequencer.sv @@
// Top level of the four-bit character display sequencer: configuration registers
// and the front end, job queue and phase generator. Depends on lcd4_pkg.
//
// Usage:
//   Requests enter on the slave stream: tuser is the request kind (init, command
//   byte, data byte, cursor move), tdata carries byte, row and column. Each request
//   becomes a run of pin phases on the master stream, one transfer per phase, with
//   tlast on the final phase of the run. Each phase gives register select, enable,
//   the data nibble and the number of clock ticks to hold them.
//   A request passes through the job queue, the job register of the phase generator
//   and its output register before its first phase appears. Throughput: one phase per
//   cycle while the receiver takes them; a byte request gives 4 phases and an init
//   request 25. This is set by the phase generator, which builds one phase per cycle
//   while its output slot is free. The job queue holds QUEUE_DEPTH requests, so new
//   requests are taken while the current one is still being emitted.
//   Configuration writes arrive on their own channel (index, data) and are always
//   taken; they are meant to happen only while no request is in flight.
//   Reset clears the queue and output and loads the register defaults. When the
//   receiver stalls, the current phase holds on the output and the generator waits;
//   requests keep entering until the queue fills.
module char_lcd_4bit_interface_sequencer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [7:0] byte_value, [8] row, [14:9] column, [15] zero
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] req_type
    // Pin phase stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // [0] rs_level, [1] enable_level, [5:2] data_nibble,
                                         // [29:6] wait_ticks, [31:30] zero
    output logic        o_m_axis_tlast,
    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import lcd4_pkg::*;

    t_cfg   r_cfg;
    logic   q_push, q_full, q_pop, q_valid;
    t_job   front_job, q_job;
    t_phase out_phase;

    // Configuration registers; indexes beyond the list are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_unit_ticks     <= 8'd10;
            r_cfg.millisecond_ticks    <= 16'd5000;
            r_cfg.function_set_byte    <= 8'h28;
            r_cfg.display_control_byte <= 8'h0C;
            r_cfg.entry_mode_byte      <= 8'h06;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SHORT_UNIT:   r_cfg.short_unit_ticks     <= i_cfg_data[7:0];
                CFG_MILLISECOND:  r_cfg.millisecond_ticks    <= i_cfg_data;
                CFG_FUNCTION_SET: r_cfg.function_set_byte    <= i_cfg_data[7:0];
                CFG_DISPLAY_CTRL: r_cfg.display_control_byte <= i_cfg_data[7:0];
                CFG_ENTRY_MODE:   r_cfg.entry_mode_byte      <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Request intake and classification.
    lcd4_front u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_job           (front_job)
    );

    // Job queue.
    lcd4_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    // Phase generation.
    lcd4_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_valid       (q_valid),
        .i_q_job         (q_job),
        .o_q_pop         (q_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_phase         (out_phase)
    );

    assign o_m_axis_tdata = {2'b00, out_phase.wait_ticks, out_phase.nibble,
                             out_phase.en, out_phase.rs};
    assign o_m_axis_tlast = out_phase.last;

endmodule
